### rtl/sst_pkg.sv
// Shared types and constants for the section translation table.
// Used by sst_ctrl, sst_dp and section_translation_table; no dependencies.
package sst_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned ST_W      = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SEC_SHIFT = 20;

  localparam logic [31:0] SECTION_BASE_MASK   = 32'hFFF0_0000;
  localparam logic [31:0] SECTION_OFFSET_MASK = 32'h000F_FFFF;
  localparam logic [31:0] SECTION_STEP        = 32'h0010_0000;

  localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD       = 2'd1;
  localparam logic [OP_W-1:0] OP_FILL      = 2'd2;

  localparam logic [ST_W-1:0] STS_OK          = 3'd0;
  localparam logic [ST_W-1:0] STS_NULL        = 3'd1;
  localparam logic [ST_W-1:0] STS_NOT_SECTION = 3'd2;
  localparam logic [ST_W-1:0] STS_DENIED      = 3'd3;
  localparam logic [ST_W-1:0] STS_WRITTEN     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECT_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERM_MASK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERM_REQ  = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic clr;
    logic accept;
    logic add_wr;
    logic fill_wr;
    logic resp_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic fill_stop;
    logic fill_last;
    logic out_free;
  } sts_t;

endpackage

### rtl/section_translation_table.sv
// Top level of the section translation table: sst_ctrl plus sst_dp.
// Depends on sst_pkg, sst_ctrl and sst_dp.
//
//  channel | dir | handshake            | payload
//  in      | in  | in_tvalid/in_tready  | in_tdata (136 bits)
//  out     | out | out_tvalid/out_tready| out_tdata (40 bits)
//  cfg     | in  | cfg_wr_en            | cfg_index, cfg_wr_data
//
// After reset the table is zeroed, one entry a cycle, with in_tready low until
// every entry is written. Translate and add-section do a registered read of the
// descriptor memory and take no new transfer until the result is loaded.
// Identity fill does one memory write a cycle and ends at range_end or at the
// end of the table. A stalled output holds the result in its register; the
// next transfer is still taken, its result waits until it leaves.
module section_translation_table #(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] opcode, [33:2] virt_addr, [65:34] target_address,
  // [97:66] range_end, [129:98] protection_bits, [135:130] zero
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] physical_address, [34:32] status, [39:35] zero
  output logic [39:0]  out_tdata,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wr_data
);

  sst_pkg::cmd_t cmd;
  sst_pkg::sts_t sts;
  logic [31:0] out_pa;
  logic [sst_pkg::ST_W-1:0] out_status;

  sst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tdata[1:0]),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sst_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_va       (in_tdata[33:2]),
    .in_ta       (in_tdata[65:34]),
    .in_end      (in_tdata[97:66]),
    .in_prot     (in_tdata[129:98]),
    .in_op       (in_tdata[1:0]),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_pa      (out_pa),
    .out_status  (out_status)
  );

  assign out_tdata = {5'd0, out_status, out_pa};

endmodule

### rtl/sst_ctrl.sv
// Controller FSM: table clear after reset, accept, fill sequencing, response.
// Depends on sst_pkg.
module sst_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic [sst_pkg::OP_W-1:0]      in_op,
  output logic                          in_tready,
  input  sst_pkg::sts_t                 sts,
  output sst_pkg::cmd_t                 cmd
);

  sst_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sst_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      sst_pkg::ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clear_last) state_nxt = sst_pkg::ST_IDLE;
      end
      sst_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (in_op == sst_pkg::OP_ADD) begin
            cmd.add_wr = 1'b1;
            state_nxt  = sst_pkg::ST_RESP;
          end else if (in_op == sst_pkg::OP_FILL) begin
            state_nxt = sst_pkg::ST_FILL;
          end else begin
            state_nxt = sst_pkg::ST_RESP;
          end
        end
      end
      sst_pkg::ST_FILL: begin
        if (sts.fill_stop) begin
          state_nxt = sst_pkg::ST_RESP;
        end else begin
          cmd.fill_wr = 1'b1;
          if (sts.fill_last) state_nxt = sst_pkg::ST_RESP;
        end
      end
      sst_pkg::ST_RESP: begin
        if (sts.out_free) begin
          cmd.resp_load = 1'b1;
          state_nxt     = sst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sst_pkg::ST_CLEAR;
    endcase
  end

  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> state_r == sst_pkg::ST_CLEAR)
    else $error("clear pass not started after reset");
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sst_pkg::ST_CLEAR |-> !in_tready)
    else $error("input taken during clear pass");
  a_fill_write_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill_wr |-> state_r == sst_pkg::ST_FILL && !sts.fill_stop)
    else $error("fill write past range end");
  a_resp_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.resp_load |-> sts.out_free)
    else $error("result overwrites a pending transfer");

endmodule

### rtl/sst_dp.sv
// Datapath: config registers, descriptor memory, fill address, result register.
// Depends on sst_pkg; driven by sst_ctrl commands.
module sst_dp #(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [sst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_wr_data,
  input  logic [31:0]                       in_va,
  input  logic [31:0]                       in_ta,
  input  logic [31:0]                       in_end,
  input  logic [31:0]                       in_prot,
  input  logic [sst_pkg::OP_W-1:0]          in_op,
  input  sst_pkg::cmd_t                     cmd,
  output sst_pkg::sts_t                     sts,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_pa,
  output logic [sst_pkg::ST_W-1:0]          out_status
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [12:0] ENTRIES_13 = 13'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [31:0] type_mask_r, sect_code_r, perm_mask_r, perm_req_r;
  logic [31:0] mem [TABLE_ENTRIES];
  logic [31:0] rd_r;
  logic [31:0] va_r, end_r, prot_r, addr_r;
  logic        xlat_r, rng_r;
  logic [IDX_W-1:0] clr_cnt_r;
  logic        out_vld_r, out_vld_nxt;
  logic [31:0] out_pa_r;
  logic [sst_pkg::ST_W-1:0] out_st_r;

  logic [11:0] va_sec, addr_sec;
  logic        va_in_rng, addr_in_rng;
  logic        we;
  logic [IDX_W-1:0] wa;
  logic [31:0] wd;
  logic [31:0] desc;
  logic [31:0] res_pa;
  logic [sst_pkg::ST_W-1:0] res_st;

  assign va_sec      = in_va[31:sst_pkg::SEC_SHIFT];
  assign addr_sec    = addr_r[31:sst_pkg::SEC_SHIFT];
  assign va_in_rng   = {1'b0, va_sec} < ENTRIES_13;
  assign addr_in_rng = {1'b0, addr_sec} < ENTRIES_13;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_mask_r <= 32'd3;
      sect_code_r <= 32'd2;
      perm_mask_r <= 32'd3072;
      perm_req_r  <= 32'd3072;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sst_pkg::CFG_TYPE_MASK: type_mask_r <= cfg_wr_data;
        sst_pkg::CFG_SECT_CODE: sect_code_r <= cfg_wr_data;
        sst_pkg::CFG_PERM_MASK: perm_mask_r <= cfg_wr_data;
        sst_pkg::CFG_PERM_REQ:  perm_req_r  <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    priority if (cmd.clr) begin
      we = 1'b1;
      wa = clr_cnt_r;
    end else if (cmd.add_wr) begin
      we = va_in_rng;
      wa = va_sec[IDX_W-1:0];
      wd = (in_ta & sst_pkg::SECTION_BASE_MASK) | in_prot | sect_code_r;
    end else if (cmd.fill_wr) begin
      we = 1'b1;
      wa = addr_sec[IDX_W-1:0];
      wd = (addr_r & sst_pkg::SECTION_BASE_MASK) | prot_r | sect_code_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) rd_r <= mem[va_sec[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      va_r   <= in_va;
      end_r  <= in_end;
      prot_r <= in_prot;
      addr_r <= in_ta;
      xlat_r <= (in_op != sst_pkg::OP_ADD) && (in_op != sst_pkg::OP_FILL);
      rng_r  <= va_in_rng;
    end else if (cmd.fill_wr) begin
      addr_r <= addr_r + sst_pkg::SECTION_STEP;
    end
  end

  assign desc = rng_r ? rd_r : 32'd0;

  always_comb begin
    res_pa = '0;
    if (!xlat_r) begin
      res_st = sst_pkg::STS_WRITTEN;
    end else if (va_r == 32'd0) begin
      res_st = sst_pkg::STS_NULL;
    end else if ((desc & type_mask_r) != sect_code_r) begin
      res_st = sst_pkg::STS_NOT_SECTION;
    end else if ((desc & perm_mask_r) != perm_req_r) begin
      res_st = sst_pkg::STS_DENIED;
    end else begin
      res_st = sst_pkg::STS_OK;
      res_pa = (desc & sst_pkg::SECTION_BASE_MASK) | (va_r & sst_pkg::SECTION_OFFSET_MASK);
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.resp_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      out_pa_r <= res_pa;
      out_st_r <= res_st;
    end
  end

  assign sts.clear_last = (clr_cnt_r == LAST_IDX);
  assign sts.fill_stop  = !(addr_r < end_r) || !addr_in_rng;
  assign sts.fill_last  = (addr_sec == 12'hFFF);
  assign sts.out_free   = !out_vld_r || out_tready;

  assign out_tvalid = out_vld_r;
  assign out_pa     = out_pa_r;
  assign out_status = out_st_r;

endmodule
